// File: sv/kmb_pkg.sv
// Shared types, constants and helpers for the keyed mailbox with history queue.
package kmb_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int RING_DEPTH_DEF  = 32;
   localparam int DRAIN_LIMIT_DEF = 32;
   localparam logic [31:0] HIST_MIN_RESET = 32'd1000000000;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_HIST  = 2'd1,
      OP_DRAIN = 2'd2,
      OP_AGE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_DROPPED = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SLOT_RD,
      S_SLOT_CHK,
      S_PUT_WR,
      S_HIST_WR,
      S_RING_START,
      S_RING_RD,
      S_RING_CHK,
      S_CMP_RD,
      S_CMP_CHK,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type      action;
      logic [63:0] node_key;
      logic [63:0] metric_key;
      logic [31:0] unit_code;
      logic [31:0] value_bits;
      logic [31:0] source_ts;
      logic [31:0] now_ms;
      logic [5:0]  max_out;
      logic [31:0] stale_after_ms;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        is_reading;
      logic [63:0] out_metric;
      logic [31:0] out_unit;
      logic [31:0] out_value;
      logic [31:0] out_timestamp;
      logic        stale;
      logic [31:0] age_ms;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] node;
      logic [63:0] metric;
      logic [31:0] unit;
      logic [31:0] value;
      logic [31:0] src_ts;
      logic [31:0] rcv_ms;
   } slot_entry_type;

   typedef struct packed {
      logic [63:0] node;
      logic [63:0] metric;
      logic [31:0] unit;
      logic [31:0] value;
      logic [31:0] src_ts;
   } ring_entry_type;

   typedef struct packed {
      logic        node_eq;
      logic        pair_eq;
      logic [31:0] age;
      logic        stale;
      logic        age_lt;
   } cmp_res_type;

   // Empty keys and infinite or NaN values are refused.
   function automatic logic is_bad(input logic [63:0] node, input logic [63:0] metric,
                                   input logic [31:0] value);
      return (node == 64'd0) || (metric == 64'd0) || (value[30:23] == 8'hFF);
   endfunction

endpackage

// File: sv/kmb_req_if.sv
// Request channel: valid/ready handshake with the input item fields.
interface kmb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] node_key;
   logic [63:0] metric_key;
   logic [31:0] unit_code;
   logic [31:0] value_bits;
   logic [31:0] source_ts;
   logic [31:0] now_ms;
   logic [5:0]  max_out;
   logic [31:0] stale_after_ms;

   modport source(output valid, action, node_key, metric_key, unit_code, value_bits,
                  source_ts, now_ms, max_out, stale_after_ms, input ready);
   modport sink(input valid, action, node_key, metric_key, unit_code, value_bits,
                source_ts, now_ms, max_out, stale_after_ms, output ready);
endinterface

// File: sv/kmb_rsp_if.sv
// Response channel: valid/ready handshake with the result item fields.
interface kmb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        is_reading;
   logic [63:0] out_metric;
   logic [31:0] out_unit;
   logic [31:0] out_value;
   logic [31:0] out_timestamp;
   logic        stale;
   logic [31:0] age_ms;
   logic        last;

   modport source(output valid, status, is_reading, out_metric, out_unit, out_value,
                  out_timestamp, stale, age_ms, last, input ready);
   modport sink(input valid, status, is_reading, out_metric, out_unit, out_value,
                out_timestamp, stale, age_ms, last, output ready);
endinterface

// File: sv/kmb_ram.sv
// Generic RAM with one write port and one registered read port.
module kmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/kmb_cmp.sv
// Shared compare unit: key equality, receive age, staleness and minimum test.
module kmb_cmp import kmb_pkg::*; (
   input  logic [63:0] a_node,
   input  logic [63:0] b_node,
   input  logic [63:0] a_metric,
   input  logic [63:0] b_metric,
   input  logic [31:0] now_ms,
   input  logic [31:0] stamp_ms,
   input  logic [31:0] stale_ms,
   input  logic [31:0] best_ms,
   output cmp_res_type res
);

   logic [31:0] age;

   assign age = now_ms - stamp_ms;

   always_comb begin
      res.node_eq = (a_node == b_node);
      res.pair_eq = (a_node == b_node) && (a_metric == b_metric);
      res.age     = age;
      res.stale   = (stale_ms != 32'd0) && (age > stale_ms);
      res.age_lt  = (age < best_ms);
   end

endmodule

// File: sv/keyed_mailbox_with_history_queue.sv
// Keyed mailbox: latest-value table, history ring and the sequencer that drives them.
// Sequence: a put or age query scans the table slot by slot, reading then checking
// each slot; a historical put writes the ring directly; a drain scans the table,
// then the ring entry by entry, then compacts the ring back to front.
// Throughput: one item at a time; the next item is taken when the sequencer is idle.
// Reset clears slot valid bits, ring head and count, and sets hist_min_ff to 1e9.
module keyed_mailbox_with_history_queue import kmb_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF,
   parameter int DRAIN_LIMIT = DRAIN_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   kmb_req_if.sink     req_if,
   kmb_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int RPW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int LW  = $clog2(DRAIN_LIMIT + 1);
   localparam int SLOT_W = $bits(slot_entry_type);
   localparam int RING_W = $bits(ring_entry_type);

   function automatic logic [RPW-1:0] ring_wrap(input logic [CW:0] s);
      logic [CW:0] t;
      t = (s >= (CW+1)'(RING_DEPTH)) ? (s - (CW+1)'(RING_DEPTH)) : s;
      return t[RPW-1:0];
   endfunction

   state_type          state_ff, state_in;
   req_type            cur_ff, cur_in;
   logic [31:0]        hist_min_ff;
   logic [TABLE_SLOTS-1:0] slot_used_ff, slot_used_in;
   logic [SW-1:0]      slot_idx_ff, slot_idx_in;
   logic [SW-1:0]      hole_ff, hole_in;
   logic               hole_found_ff, hole_found_in;
   logic [SW-1:0]      put_addr_ff, put_addr_in;
   logic [RPW-1:0]     head_ff, head_in;
   logic [CW-1:0]      ring_count_ff, ring_count_in;
   logic [CW-1:0]      ring_j_ff, ring_j_in;
   logic [CW-1:0]      ring_w_ff, ring_w_in;
   logic [CW-1:0]      jlast_ff, jlast_in;
   logic [CW-1:0]      removed_ff, removed_in;
   logic [LW-1:0]      n_ff, n_in;
   logic [LW-1:0]      limit_ff, limit_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            pend_ff, pend_in;
   logic [31:0]        best_ff, best_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               rsp_load;
   rsp_type            rsp_load_data;
   logic               slot_we;
   logic [SLOT_W-1:0]  slot_rd_bits;
   slot_entry_type     slot_rd;
   slot_entry_type     slot_wr;
   logic               ring_we;
   logic [RPW-1:0]     ring_wr_addr;
   logic [RPW-1:0]     ring_rd_addr;
   logic [RING_W-1:0]  ring_rd_bits;
   ring_entry_type     ring_rd;
   ring_entry_type     ring_wr;
   logic               ring_phase;
   cmp_res_type        cmp;

   assign slot_rd = slot_entry_type'(slot_rd_bits);
   assign ring_rd = ring_entry_type'(ring_rd_bits);
   assign ring_rd_addr = ring_wrap((CW+1)'(head_ff) + (CW+1)'(ring_j_ff));
   assign ring_phase = (state_ff == S_RING_CHK) || (state_ff == S_CMP_CHK);

   assign slot_wr = '{node: cur_ff.node_key, metric: cur_ff.metric_key,
                      unit: cur_ff.unit_code, value: cur_ff.value_bits,
                      src_ts: cur_ff.source_ts, rcv_ms: cur_ff.now_ms};

   kmb_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (put_addr_ff),
      .wr_data (SLOT_W'(slot_wr)),
      .rd_addr (slot_idx_ff),
      .rd_data (slot_rd_bits)
   );

   kmb_ram #(.WIDTH(RING_W), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wr_addr),
      .wr_data (RING_W'(ring_wr)),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_bits)
   );

   kmb_cmp u_cmp (
      .a_node   (ring_phase ? ring_rd.node : slot_rd.node),
      .b_node   (cur_ff.node_key),
      .a_metric (slot_rd.metric),
      .b_metric (cur_ff.metric_key),
      .now_ms   (cur_ff.now_ms),
      .stamp_ms (slot_rd.rcv_ms),
      .stale_ms (cur_ff.stale_after_ms),
      .best_ms  (best_ff),
      .res      (cmp)
   );

   assign req_if.ready = (state_ff == S_IDLE);

   always_comb begin
      logic used_now;
      logic take;
      logic blocked;
      logic slot_end;
      state_in       = state_ff;
      cur_in         = cur_ff;
      slot_used_in   = slot_used_ff;
      slot_idx_in    = slot_idx_ff;
      hole_in        = hole_ff;
      hole_found_in  = hole_found_ff;
      put_addr_in    = put_addr_ff;
      head_in        = head_ff;
      ring_count_in  = ring_count_ff;
      ring_j_in      = ring_j_ff;
      ring_w_in      = ring_w_ff;
      jlast_in       = jlast_ff;
      removed_in     = removed_ff;
      n_in           = n_ff;
      limit_in       = limit_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      best_in        = best_ff;
      status_in      = status_ff;
      rsp_load       = 1'b0;
      rsp_load_data  = '0;
      slot_we        = 1'b0;
      ring_we        = 1'b0;
      ring_wr_addr   = ring_wrap((CW+1)'(head_ff) + (CW+1)'(ring_w_ff));
      ring_wr        = ring_rd;
      used_now       = slot_used_ff[slot_idx_ff];
      slot_end       = (slot_idx_ff == SW'(TABLE_SLOTS - 1));
      take           = 1'b0;
      blocked        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cur_in.action         = op_type'(req_if.action);
               cur_in.node_key       = req_if.node_key;
               cur_in.metric_key     = req_if.metric_key;
               cur_in.unit_code      = req_if.unit_code;
               cur_in.value_bits     = req_if.value_bits;
               cur_in.source_ts      = req_if.source_ts;
               cur_in.now_ms         = req_if.now_ms;
               cur_in.max_out        = req_if.max_out;
               cur_in.stale_after_ms = req_if.stale_after_ms;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            slot_idx_in   = '0;
            hole_found_in = 1'b0;
            n_in          = '0;
            removed_in    = '0;
            pend_valid_in = 1'b0;
            best_in       = 32'hFFFF_FFFF;
            status_in     = STAT_OK;
            limit_in = (32'(cur_ff.max_out) > 32'(DRAIN_LIMIT)) ? LW'(DRAIN_LIMIT)
                                                                : LW'(cur_ff.max_out);
            unique case (cur_ff.action)
               OP_PUT: begin
                  if (is_bad(cur_ff.node_key, cur_ff.metric_key, cur_ff.value_bits)) begin
                     status_in = STAT_INVALID;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_SLOT_RD;
                  end
               end
               OP_HIST: begin
                  if (is_bad(cur_ff.node_key, cur_ff.metric_key, cur_ff.value_bits) ||
                      (cur_ff.source_ts < hist_min_ff)) begin
                     status_in = STAT_INVALID;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_HIST_WR;
                  end
               end
               OP_DRAIN, OP_AGE: begin
                  state_in = S_SLOT_RD;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SLOT_RD: begin
            state_in = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            unique case (cur_ff.action)
               OP_PUT: begin
                  if (used_now && cmp.pair_eq) begin
                     put_addr_in = slot_idx_ff;
                     state_in    = S_PUT_WR;
                  end else begin
                     if (!used_now && !hole_found_ff) begin
                        hole_found_in = 1'b1;
                        hole_in       = slot_idx_ff;
                     end
                     if (slot_end) begin
                        if (hole_found_ff || !used_now) begin
                           put_addr_in = hole_found_ff ? hole_ff : slot_idx_ff;
                           state_in    = S_PUT_WR;
                        end else begin
                           status_in = STAT_FULL;
                           state_in  = S_FINISH;
                        end
                     end else begin
                        slot_idx_in = slot_idx_ff + SW'(1);
                        state_in    = S_SLOT_RD;
                     end
                  end
               end
               OP_DRAIN: begin
                  if (n_ff >= limit_ff) begin
                     ring_j_in = '0;
                     state_in  = S_RING_START;
                  end else begin
                     take    = used_now && cmp.node_eq;
                     blocked = take && pend_valid_ff && rsp_valid_ff;
                     if (!blocked) begin
                        if (take) begin
                           rsp_load      = pend_valid_ff;
                           rsp_load_data = pend_ff;
                           pend_valid_in = 1'b1;
                           pend_in       = '{status: STAT_OK, is_reading: 1'b1,
                                             out_metric: slot_rd.metric,
                                             out_unit: slot_rd.unit,
                                             out_value: slot_rd.value,
                                             out_timestamp: slot_rd.src_ts,
                                             stale: cmp.stale, age_ms: 32'd0,
                                             last: 1'b0};
                           n_in = n_ff + LW'(1);
                        end
                        if (slot_end) begin
                           ring_j_in = '0;
                           state_in  = S_RING_START;
                        end else begin
                           slot_idx_in = slot_idx_ff + SW'(1);
                           state_in    = S_SLOT_RD;
                        end
                     end
                  end
               end
               default: begin
                  if (used_now && cmp.node_eq && cmp.age_lt) begin
                     best_in = cmp.age;
                  end
                  if (slot_end) begin
                     state_in = S_FINISH;
                  end else begin
                     slot_idx_in = slot_idx_ff + SW'(1);
                     state_in    = S_SLOT_RD;
                  end
               end
            endcase
         end
         S_PUT_WR: begin
            slot_we = 1'b1;
            slot_used_in[put_addr_ff] = 1'b1;
            status_in = STAT_OK;
            state_in  = S_FINISH;
         end
         S_HIST_WR: begin
            ring_we = 1'b1;
            ring_wr = '{node: cur_ff.node_key, metric: cur_ff.metric_key,
                        unit: cur_ff.unit_code, value: cur_ff.value_bits,
                        src_ts: cur_ff.source_ts};
            if (ring_count_ff == CW'(RING_DEPTH)) begin
               // Overwrite the oldest entry and advance the head past it.
               ring_wr_addr = head_ff;
               head_in      = ring_wrap((CW+1)'(head_ff) + (CW+1)'(1));
               status_in    = STAT_DROPPED;
            end else begin
               ring_wr_addr  = ring_wrap((CW+1)'(head_ff) + (CW+1)'(ring_count_ff));
               ring_count_in = ring_count_ff + CW'(1);
               status_in     = STAT_OK;
            end
            state_in = S_FINISH;
         end
         S_RING_START: begin
            if ((n_ff < limit_ff) && (ring_j_ff < ring_count_ff)) begin
               state_in = S_RING_RD;
            end else if (removed_ff != '0) begin
               ring_j_in = jlast_ff;
               ring_w_in = jlast_ff;
               state_in  = S_CMP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RING_RD: begin
            state_in = S_RING_CHK;
         end
         S_RING_CHK: begin
            take    = cmp.node_eq;
            blocked = take && pend_valid_ff && rsp_valid_ff;
            if (!blocked) begin
               if (take) begin
                  rsp_load      = pend_valid_ff;
                  rsp_load_data = pend_ff;
                  pend_valid_in = 1'b1;
                  pend_in       = '{status: STAT_OK, is_reading: 1'b1,
                                    out_metric: ring_rd.metric, out_unit: ring_rd.unit,
                                    out_value: ring_rd.value,
                                    out_timestamp: ring_rd.src_ts,
                                    stale: 1'b0, age_ms: 32'd0, last: 1'b0};
                  n_in       = n_ff + LW'(1);
                  removed_in = removed_ff + CW'(1);
                  jlast_in   = ring_j_ff;
               end
               ring_j_in = ring_j_ff + CW'(1);
               state_in  = S_RING_START;
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_CHK;
         end
         S_CMP_CHK: begin
            // Walk back from the last removed entry, sliding kept entries toward the tail.
            if (!cmp.node_eq) begin
               ring_we   = 1'b1;
               ring_w_in = ring_w_ff - CW'(1);
            end
            if (ring_j_ff == '0) begin
               head_in       = ring_wrap((CW+1)'(head_ff) + (CW+1)'(removed_ff));
               ring_count_in = ring_count_ff - removed_ff;
               state_in      = S_FINISH;
            end else begin
               ring_j_in = ring_j_ff - CW'(1);
               state_in  = S_CMP_RD;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff) begin
               rsp_load = 1'b1;
               rsp_load_data = '0;
               rsp_load_data.last = 1'b1;
               unique case (cur_ff.action)
                  OP_PUT, OP_HIST: rsp_load_data.status = status_ff;
                  OP_DRAIN: begin
                     if (pend_valid_ff) begin
                        rsp_load_data      = pend_ff;
                        rsp_load_data.last = 1'b1;
                     end
                  end
                  default: rsp_load_data.age_ms = best_ff;
               endcase
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_load_data;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hist_min_ff   <= HIST_MIN_RESET;
         slot_used_ff  <= '0;
         head_ff       <= '0;
         ring_count_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            hist_min_ff <= csr_wdata;
         end
         slot_used_ff  <= slot_used_in;
         head_ff       <= head_in;
         ring_count_ff <= ring_count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      slot_idx_ff   <= slot_idx_in;
      hole_ff       <= hole_in;
      hole_found_ff <= hole_found_in;
      put_addr_ff   <= put_addr_in;
      ring_j_ff     <= ring_j_in;
      ring_w_ff     <= ring_w_in;
      jlast_ff      <= jlast_in;
      removed_ff    <= removed_in;
      n_ff          <= n_in;
      limit_ff      <= limit_in;
      pend_ff       <= pend_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_ff.status;
   assign rsp_if.is_reading    = rsp_ff.is_reading;
   assign rsp_if.out_metric    = rsp_ff.out_metric;
   assign rsp_if.out_unit      = rsp_ff.out_unit;
   assign rsp_if.out_value     = rsp_ff.out_value;
   assign rsp_if.out_timestamp = rsp_ff.out_timestamp;
   assign rsp_if.stale         = rsp_ff.stale;
   assign rsp_if.age_ms        = rsp_ff.age_ms;
   assign rsp_if.last          = rsp_ff.last;

   a_ring_count_bound: assert property (@(posedge clock) disable iff (reset)
      ring_count_ff <= CW'(RING_DEPTH))
      else $error("ring count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < 32'(RING_DEPTH))
      else $error("ring head out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(rsp_load && rsp_valid_ff))
      else $error("result register loaded while an item still waits");

   a_drain_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RING_CHK || state_ff == S_SLOT_CHK) |-> (n_ff <= limit_ff))
      else $error("drain returned more items than allowed");

   a_full_stays_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HIST_WR && ring_count_ff == CW'(RING_DEPTH))
      |=> (ring_count_ff == CW'(RING_DEPTH)))
      else $error("full ring lost an entry on a historical put");

endmodule
